/* hw/rtl/ffa_pkg.sv */
// shared types and constants for the first-fit arena allocator
// no dependencies
package ffa_pkg;
  localparam int ArenaWords = 4096;
  localparam int HeaderWords = 4;
  localparam int AddrW = 12;
  localparam int LinkW = 13;
  localparam int SizeW = 16;
  localparam logic [SizeW-1:0] SplitMin = SizeW'(2 * HeaderWords);
  localparam logic [SizeW-1:0] SizeCap = {SizeW{1'b1}};
  localparam logic [15:0] LimitReset = 16'd32768;
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;
  localparam logic [1:0] RegLimit = 2'd0;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic used;
    logic [LinkW-1:0] link;
  } hdr_t;

  function automatic logic link_ok(input logic [LinkW-1:0] l);
    link_ok = (l != '0) && ({1'b0, l} - 14'd1 < 14'(ArenaWords));
  endfunction

  function automatic logic [SizeW-1:0] merge(input logic [SizeW-1:0] a,
                                            input logic [SizeW-1:0] b);
    logic [SizeW+1:0] s;
    s = {2'b0, a} + (SizeW+2)'(HeaderWords) + {2'b0, b};
    merge = (s > {2'b0, SizeCap}) ? SizeCap : s[SizeW-1:0];
  endfunction
endpackage

/* hw/rtl/ffa_hdr_ram.sv */
// header store, one read and one write port, registered read data
// depends on ffa_pkg
module ffa_hdr_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ffa_pkg::AddrW-1:0] waddr,
  input  ffa_pkg::hdr_t             wdata,
  input  logic [ffa_pkg::AddrW-1:0] raddr,
  output ffa_pkg::hdr_t             rdata
);
  ffa_pkg::hdr_t mem [ffa_pkg::ArenaWords];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/first_fit_arena_allocator.sv */
// first-fit arena allocator: an ignored free goes straight to done; otherwise each header
// read (walk nodes, successor probes, free merges) has a read and a check state, a split
// writes the remainder header, and a carved block is linked behind the tail
// one item at a time: the next item is taken at the edge that ends the one-cycle strobe
// synchronous reset clears break and list head/tail and sets limit to its reset value; header ram not cleared
// depends on ffa_pkg and ffa_hdr_ram
module first_fit_arena_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [14:0] req_bytes,
  input  logic [14:0] free_offset,
  output logic        done,
  output logic [14:0] payload_offset,
  output logic        out_of_memory,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = ffa_pkg::AddrW;
  localparam int LW = ffa_pkg::LinkW;
  localparam int SW = ffa_pkg::SizeW;
  localparam logic [12:0] WalkMax = 13'(ffa_pkg::ArenaWords + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_NRD   = 4'd3;
  localparam logic [3:0] S_NCHK  = 4'd4;
  localparam logic [3:0] S_TAKE  = 4'd5;
  localparam logic [3:0] S_SPLIT = 4'd6;
  localparam logic [3:0] S_CARVE = 4'd7;
  localparam logic [3:0] S_TRD   = 4'd8;
  localparam logic [3:0] S_TLINK = 4'd9;
  localparam logic [3:0] S_FRD   = 4'd10;
  localparam logic [3:0] S_FCHK  = 4'd11;
  localparam logic [3:0] S_FNRD  = 4'd12;
  localparam logic [3:0] S_FNCHK = 4'd13;
  localparam logic [3:0] S_FEND  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state;
  logic [15:0] limit;
  logic [LW-1:0] brk, head, tail, cur;
  logic [SW-1:0] need;
  ffa_pkg::hdr_t hcur;
  logic [AW-1:0] raddr, waddr;
  logic we;
  ffa_pkg::hdr_t wdata, rdata;
  logic [12:0] walk_n;
  logic oom;
  logic [14:0] pay;

  ffa_hdr_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  logic [AW-1:0] h;
  logic [LW-1:0] nx;
  ffa_pkg::hdr_t succ;
  logic [SW-1:0] mrg, spare;
  logic [SW+1:0] rpos, carve_end;
  logic [12:0] lim_w;
  logic split_ok;
  assign h = cur[AW-1:0] - AW'(1);
  assign nx = hcur.link;
  // a block linked to itself sees its own pending header
  assign succ = (nx == cur) ? hcur : rdata;
  assign mrg = ffa_pkg::merge(hcur.size, succ.size);
  assign spare = hcur.size - need;
  assign rpos = (SW+2)'(h) + (SW+2)'(ffa_pkg::HeaderWords) + {2'b0, need};
  assign carve_end = (SW+2)'(brk) + (SW+2)'(ffa_pkg::HeaderWords) + {2'b0, need};
  assign lim_w = (limit[15:3] > 13'(ffa_pkg::ArenaWords)) ?
                 13'(ffa_pkg::ArenaWords) : limit[15:3];
  assign split_ok = (spare > ffa_pkg::SplitMin) && (rpos < (SW+2)'(ffa_pkg::ArenaWords));

  always_comb begin
    raddr = nx[AW-1:0] - AW'(1);
    if (state == S_RD || state == S_FRD) raddr = h;
    we = 1'b0;
    waddr = h;
    wdata = hcur;
    unique case (state)
      S_TAKE: begin
        we = 1'b1;
        wdata.used = 1'b1;
        if (split_ok) begin
          wdata.size = need;
          wdata.link = LW'(rpos) + LW'(1);
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = rpos[AW-1:0];
        wdata.size = spare - SW'(ffa_pkg::HeaderWords);
        wdata.used = 1'b0;
        wdata.link = hcur.link;
      end
      S_CARVE: begin
        we = (carve_end <= (SW+2)'(lim_w));
        waddr = brk[AW-1:0];
        wdata.size = need;
        wdata.used = 1'b1;
        wdata.link = '0;
      end
      S_TLINK: begin
        we = 1'b1;
        waddr = nx[AW-1:0] - AW'(1);
        wdata = rdata;
        wdata.link = cur;
      end
      S_FEND: begin
        we = 1'b1;
        wdata.used = 1'b0;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr == ffa_pkg::RegLimit) ? {16'd0, limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      limit <= ffa_pkg::LimitReset;
      brk <= '0;
      head <= '0;
      tail <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite && pready && paddr == ffa_pkg::RegLimit) begin
        limit <= pwdata[15:0];
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            oom <= 1'b0;
            pay <= '0;
            walk_n <= '0;
            if (op == ffa_pkg::OpAlloc) begin
              need <= (req_bytes == '0) ? SW'(1) : SW'((16'(req_bytes) + 16'd7) >> 3);
              cur <= head;
              state <= ffa_pkg::link_ok(head) ? S_RD : S_CARVE;
            end else if (free_offset[14:3] < 12'(ffa_pkg::HeaderWords)) begin
              state <= S_DONE;
            end else begin
              cur <= LW'(free_offset[14:3] - 12'(ffa_pkg::HeaderWords)) + LW'(1);
              state <= S_FRD;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          hcur <= rdata;
          walk_n <= walk_n + 13'd1;
          if (!rdata.used && rdata.size >= need) state <= S_TAKE;
          else if (!rdata.used && ffa_pkg::link_ok(rdata.link)) state <= S_NRD;
          else if (ffa_pkg::link_ok(rdata.link) && walk_n < WalkMax - 13'd1) begin
            cur <= rdata.link;
            state <= S_RD;
          end else state <= S_CARVE;
        end
        S_NRD: state <= S_NCHK;
        S_NCHK: begin
          if (!succ.used && mrg >= need) begin
            if (tail == nx) tail <= cur;
            hcur.size <= mrg;
            hcur.link <= succ.link;
            state <= S_TAKE;
          end else if (walk_n < WalkMax) begin
            cur <= nx;
            state <= S_RD;
          end else state <= S_CARVE;
        end
        S_TAKE: begin
          pay <= 15'((15'(h) + 15'(ffa_pkg::HeaderWords)) << 3);
          if (split_ok) begin
            if (tail == cur) tail <= LW'(rpos) + LW'(1);
            state <= S_SPLIT;
          end else state <= S_DONE;
        end
        S_SPLIT: state <= S_DONE;
        S_CARVE: begin
          if (carve_end > (SW+2)'(lim_w)) begin
            oom <= 1'b1;
            state <= S_DONE;
          end else begin
            pay <= 15'((16'(brk) + 16'(ffa_pkg::HeaderWords)) << 3);
            brk <= LW'(carve_end);
            cur <= brk + LW'(1);
            if (head == '0) head <= brk + LW'(1);
            tail <= brk + LW'(1);
            hcur.link <= tail;
            state <= ffa_pkg::link_ok(tail) ? S_TRD : S_DONE;
          end
        end
        S_TRD: state <= S_TLINK;
        S_TLINK: state <= S_DONE;
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          hcur <= rdata;
          state <= ffa_pkg::link_ok(rdata.link) ? S_FNRD : S_FEND;
        end
        S_FNRD: state <= S_FNCHK;
        S_FNCHK: begin
          if (!succ.used) begin
            walk_n <= walk_n + 13'd1;
            if (tail == nx) tail <= cur;
            hcur.size <= mrg;
            hcur.link <= succ.link;
            state <= (ffa_pkg::link_ok(succ.link) && walk_n < WalkMax - 13'd1)
                     ? S_FNRD : S_FEND;
          end else state <= S_FEND;
        end
        S_FEND: state <= S_DONE;
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign payload_offset = done ? pay : '0;
  assign out_of_memory = done & oom;

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("strobe while busy");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item not taken");
  assert property (@(posedge clk) disable iff (rst) out_of_memory |-> payload_offset == '0)
    else $error("offset on failure");
endmodule

/* verif/tb_first_fit_arena_allocator.sv */
// self-checking testbench for first_fit_arena_allocator: directed table, then random items
// checked against an in-bench first-fit predictor; apb writes set the arena limit per phase
// depends on ffa_pkg and the allocator rtl
module tb_first_fit_arena_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ArenaWords = ffa_pkg::ArenaWords;
  localparam int HeaderWords = ffa_pkg::HeaderWords;
  localparam logic [15:0] LimitReset = ffa_pkg::LimitReset;
  localparam logic OP_ALLOC = ffa_pkg::OpAlloc;
  localparam logic OP_FREE = ffa_pkg::OpFree;
  localparam logic [1:0] REG_LIMIT = ffa_pkg::RegLimit;
  localparam int WALK_MAX = ArenaWords + 1;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [14:0] off;
    logic oom;
  } grant_t;

  typedef struct {
    logic op;
    logic [14:0] req;
    logic [14:0] foff;
    bit typed;
    grant_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic op = 1'b0;
  logic [14:0] req_bytes = '0;
  logic [14:0] free_offset = '0;
  logic done;
  logic [14:0] payload_offset;
  logic out_of_memory;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  first_fit_arena_allocator dut (.*);

  always #5 clk = ~clk;

  // predictor state, links stored as address + 1 with 0 for none
  int unsigned blk_size [ArenaWords];
  bit blk_used [ArenaWords];
  int unsigned blk_next [ArenaWords];
  bit hdr_valid [ArenaWords];
  int unsigned brk, head, tail, limit_bytes;
  int unsigned hdr_list [$];
  logic [14:0] live_offs [$];
  grant_t pending [$];
  int errors = 0;
  int idle_cyc = 0;

  function automatic bit link_good(int unsigned l);
    return l != 0 && (l - 1) < ArenaWords;
  endfunction

  function automatic int unsigned joined_size(int unsigned a, int unsigned b);
    int unsigned s;
    s = blk_size[a] + HeaderWords + blk_size[b];
    return s > 65535 ? 65535 : s;
  endfunction

  function automatic void swallow_next(int unsigned h);
    int unsigned nx;
    nx = blk_next[h];
    if (tail == nx) tail = h + 1;
    blk_size[h] = joined_size(h, nx - 1);
    blk_next[h] = blk_next[nx - 1];
  endfunction

  function automatic void mark_written(int unsigned h);
    if (!hdr_valid[h]) hdr_list.push_back(h);
    hdr_valid[h] = 1'b1;
  endfunction

  function automatic int unsigned first_fit(int unsigned need);
    int unsigned cur, h, nx;
    cur = head;
    for (int n = 0; n < WALK_MAX && link_good(cur); n++) begin
      h = cur - 1;
      if (!blk_used[h]) begin
        nx = blk_next[h];
        if (blk_size[h] >= need) return cur;
        if (link_good(nx) && !blk_used[nx - 1] && joined_size(h, nx - 1) >= need) begin
          swallow_next(h);
          return cur;
        end
      end
      cur = blk_next[h];
    end
    return 0;
  endfunction

  function automatic grant_t predict_grant(logic o, logic [14:0] req, logic [14:0] foff);
    grant_t g;
    int unsigned need, got, h, r, spare, lw, w;
    g = '0;
    if (o == OP_ALLOC) begin
      need = (req + 7) >> 3;
      if (need == 0) need = 1;
      got = first_fit(need);
      if (got != 0) begin
        h = got - 1;
        blk_used[h] = 1'b1;
        spare = blk_size[h] - need;
        if (spare > 2 * HeaderWords) begin
          r = h + HeaderWords + need;
          if (r < ArenaWords) begin
            blk_size[r] = spare - HeaderWords;
            blk_used[r] = 1'b0;
            blk_next[r] = blk_next[h];
            blk_next[h] = r + 1;
            mark_written(r);
            if (tail == h + 1) tail = r + 1;
            blk_size[h] = need;
          end
        end
      end else begin
        h = brk;
        lw = limit_bytes >> 3;
        if (lw > ArenaWords) lw = ArenaWords;
        if (h + HeaderWords + need > lw) begin
          g.oom = 1'b1;
          return g;
        end
        blk_size[h] = need;
        blk_used[h] = 1'b1;
        blk_next[h] = 0;
        mark_written(h);
        brk = h + HeaderWords + need;
        if (head == 0) head = h + 1;
        if (link_good(tail)) blk_next[tail - 1] = h + 1;
        tail = h + 1;
      end
      g.off = 15'((h + HeaderWords) << 3);
      return g;
    end
    w = foff >> 3;
    if (w < HeaderWords) return g;
    h = w - HeaderWords;
    if (h >= ArenaWords) return g;
    for (int n = 0; n < WALK_MAX; n++) begin
      if (!link_good(blk_next[h]) || blk_used[blk_next[h] - 1]) break;
      swallow_next(h);
    end
    blk_used[h] = 1'b0;
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    if ((start && !busy) || done) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && done) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected item off=%0d oom=%0b", $realtime, payload_offset,
                 out_of_memory);
      end else begin
        exp_g = pending.pop_front();
        if (payload_offset !== exp_g.off) begin
          errors++;
          $display("%0t: payload_offset expected %0d actual %0d", $realtime, exp_g.off,
                   payload_offset);
        end
        if (out_of_memory !== exp_g.oom) begin
          errors++;
          $display("%0t: out_of_memory expected %0b actual %0b", $realtime, exp_g.oom,
                   out_of_memory);
        end
      end
    end
  end

  task automatic set_limit(logic [15:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_LIMIT;
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== v) begin
      errors++;
      $display("%0t: limit readback expected %0d actual %0d", $realtime, v, prdata[15:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    limit_bytes = v;
    @(posedge clk);
  endtask

  task automatic issue(logic o, logic [14:0] req, logic [14:0] foff, bit typed, grant_t want,
                       int gap_pct);
    grant_t g;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    req_bytes <= req;
    free_offset <= foff;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = predict_grant(o, req, foff);
    pending.push_back(typed ? want : g);
    if (o == OP_ALLOC && !g.oom) live_offs.push_back(g.off);
  endtask

  task automatic random_items(int count, int gap_pct);
    logic o;
    logic [14:0] req, foff;
    int pick, k;
    for (int i = 0; i < count; i++) begin
      req = 15'($urandom_range(0, 32767));
      foff = 15'($urandom_range(0, 32767));
      pick = $urandom_range(0, 99);
      o = (live_offs.size() != 0 && $urandom_range(0, 99) < 45) ? OP_FREE : OP_ALLOC;
      if (o == OP_ALLOC) begin
        if (pick < 70) req = 15'($urandom_range(0, 120));
        else if (pick < 90) req = 15'($urandom_range(0, 1023));
      end else if (pick < 75) begin
        k = $urandom_range(0, live_offs.size() - 1);
        foff = live_offs[k] | 15'($urandom_range(0, 7));
        live_offs.delete(k);
      end else if (pick < 90) begin
        foff = 15'((hdr_list[$urandom_range(0, hdr_list.size() - 1)] + HeaderWords) << 3)
               | 15'($urandom_range(0, 7));
      end else begin
        foff = 15'($urandom_range(0, 31));
      end
      issue(o, req, foff, 1'b0, '0, gap_pct);
    end
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    row_t rows [$];
    brk = 0;
    head = 0;
    tail = 0;
    limit_bytes = LimitReset;
    for (int i = 0; i < ArenaWords; i++) begin
      blk_size[i] = 0;
      blk_used[i] = 1'b0;
      blk_next[i] = 0;
      hdr_valid[i] = 1'b0;
    end
    rows = '{
      '{OP_ALLOC, 15'd0, 15'd0, 1'b1, '{15'd32, 1'b0}},
      '{OP_ALLOC, 15'd1, 15'd0, 1'b1, '{15'd72, 1'b0}},
      '{OP_ALLOC, 15'd8, 15'd0, 1'b1, '{15'd112, 1'b0}},
      '{OP_ALLOC, 15'd9, 15'd0, 1'b1, '{15'd152, 1'b0}},
      '{OP_FREE, 15'd0, 15'd0, 1'b1, '{15'd0, 1'b0}},
      '{OP_FREE, 15'd0, 15'd31, 1'b1, '{15'd0, 1'b0}},
      '{OP_ALLOC, 15'd32767, 15'd0, 1'b1, '{15'd0, 1'b1}},
      '{OP_FREE, 15'd0, 15'd72, 1'b1, '{15'd0, 1'b0}},
      '{OP_ALLOC, 15'd0, 15'd0, 1'b1, '{15'd72, 1'b0}},
      '{OP_FREE, 15'd0, 15'd112, 1'b1, '{15'd0, 1'b0}},
      '{OP_FREE, 15'd0, 15'd159, 1'b1, '{15'd0, 1'b0}},
      '{OP_FREE, 15'd0, 15'd77, 1'b1, '{15'd0, 1'b0}},
      '{OP_ALLOC, 15'd80, 15'd0, 1'b0, '{15'd0, 1'b0}},
      '{OP_FREE, 15'd0, 15'd72, 1'b0, '{15'd0, 1'b0}},
      '{OP_ALLOC, 15'd0, 15'd0, 1'b0, '{15'd0, 1'b0}},
      '{OP_ALLOC, 15'd7, 15'd0, 1'b0, '{15'd0, 1'b0}},
      '{OP_ALLOC, 15'd24000, 15'd0, 1'b0, '{15'd0, 1'b0}},
      '{OP_FREE, 15'd0, 15'd32, 1'b0, '{15'd0, 1'b0}},
      '{OP_ALLOC, 15'd32767, 15'd0, 1'b0, '{15'd0, 1'b0}},
      '{OP_ALLOC, 15'd16384, 15'd0, 1'b0, '{15'd0, 1'b0}}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_limit(16'd32768);
    foreach (rows[i]) issue(rows[i].op, rows[i].req, rows[i].foff, rows[i].typed,
                            rows[i].want, 0);
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    live_offs.delete();
    set_limit(16'd256);
    random_items(300, 32);
    set_limit(16'd32768);
    random_items(700, 45);
    set_limit(16'd4096);
    random_items(400, 0);
    set_limit(16'd20000);
    random_items(550, 0);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
